### design/smbe_pkg.sv
// shared types and constants for the spi master byte exchange block
`timescale 1ns / 1ps
`default_nettype none

package smbe_pkg;

  localparam int unsigned BITS_PER_WORD = 8;
  localparam int unsigned HALF_W        = 16;
  localparam int unsigned BIT_CNT_W     = 4;
  localparam int unsigned NUM_CS        = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned GPIO_EN_W     = 2;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SELECT   = 2'd1,
    CMD_DESELECT = 2'd2,
    CMD_EXCHANGE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DEV_MAIN   = 2'd0,
    DEV_GPIO_A = 2'd1,
    DEV_GPIO_B = 2'd2
  } dev_e;

  typedef enum logic [1:0] {
    CFG_HALF_PERIOD    = 2'd0,
    CFG_GPIO_CS_ENABLE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [1:0]               device;
    logic [BITS_PER_WORD-1:0] tx_byte;
    logic                     miso;
  } req_t;

  typedef struct packed {
    logic                     sclk;
    logic                     mosi;
    logic                     cs_main_n;
    logic                     cs_gpio_a_n;
    logic                     cs_gpio_b_n;
    logic                     busy_res;
    logic                     byte_done;
    logic [BITS_PER_WORD-1:0] rx_byte;
  } res_t;

  typedef struct packed {
    cfg_idx_e              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  // configuration as seen by the back end
  typedef struct packed {
    logic [HALF_W-1:0]    half_period;
    logic [GPIO_EN_W-1:0] gpio_cs_enable;
  } cfg_t;

  // classified request held in the queue
  typedef struct packed {
    cmd_e                     cmd;
    logic [NUM_CS-1:0]        dev_mask;
    logic [BITS_PER_WORD-1:0] tx_byte;
    logic                     miso;
  } entry_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

### design/smbe_if.sv
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface smbe_req_if;
  logic          valid;
  logic          ready;
  smbe_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface smbe_res_if;
  logic          valid;
  logic          ready;
  smbe_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface smbe_cfg_if;
  logic              valid;
  logic              ready;
  smbe_pkg::cfg_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/smbe_front.sv
// front end: accepts requests and classifies command and device
`timescale 1ns / 1ps
`default_nettype none

module smbe_front (
  smbe_req_if.sink          req_i,
  input  smbe_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output smbe_pkg::entry_t  entry_o
);

  logic [smbe_pkg::NUM_CS-1:0] dev_mask;

  // device 3 maps to no select line
  always_comb begin
    unique case (req_i.payload.device)
      smbe_pkg::DEV_MAIN:   dev_mask = 3'b001;
      smbe_pkg::DEV_GPIO_A: dev_mask = 3'b010;
      smbe_pkg::DEV_GPIO_B: dev_mask = 3'b100;
      default:              dev_mask = 3'b000;
    endcase
  end

  assign req_i.ready = !q_stat_i.full;
  assign push_o      = req_i.valid && !q_stat_i.full;

  assign entry_o.cmd      = smbe_pkg::cmd_e'(req_i.payload.command);
  assign entry_o.dev_mask = dev_mask;
  assign entry_o.tx_byte  = req_i.payload.tx_byte;
  assign entry_o.miso     = req_i.payload.miso;

endmodule

`default_nettype wire

### design/smbe_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module smbe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  smbe_pkg::entry_t   entry_i,
  input  logic               pop_i,
  output smbe_pkg::entry_t   entry_o,
  output smbe_pkg::q_stat_t  stat_o
);

  smbe_pkg::entry_t mem_q [smbe_pkg::QUEUE_DEPTH];

  logic [smbe_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [smbe_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [smbe_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign do_push = push_i && (cnt_q != smbe_pkg::QUEUE_CNT_W'(smbe_pkg::QUEUE_DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q + smbe_pkg::QUEUE_PTR_W'(do_push);
    rd_ptr_d = rd_ptr_q + smbe_pkg::QUEUE_PTR_W'(do_pop);
    cnt_d    = cnt_q + smbe_pkg::QUEUE_CNT_W'(do_push) - smbe_pkg::QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o          = mem_q[rd_ptr_q];
  assign stat_o.full      = (cnt_q == smbe_pkg::QUEUE_CNT_W'(smbe_pkg::QUEUE_DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);

endmodule

`default_nettype wire

### design/smbe_back.sv
// back end: bit timing, shift register, select lines and result register
`timescale 1ns / 1ps
`default_nettype none

module smbe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smbe_pkg::cfg_t    cfg_i,
  input  smbe_pkg::q_stat_t q_stat_i,
  input  smbe_pkg::entry_t  entry_i,
  output logic              pop_o,
  smbe_res_if.source        res_o
);

  localparam int unsigned W = smbe_pkg::BITS_PER_WORD;

  logic [W-1:0]                   shift_q, shift_d;
  logic [smbe_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic                           phase_q, phase_d;
  logic [smbe_pkg::HALF_W-1:0]    tick_q, tick_d;
  logic [smbe_pkg::NUM_CS-1:0]    sel_q, sel_d;
  logic                           active_q, active_d;
  logic                           mosi_q, mosi_d;
  logic                           res_valid_q;
  smbe_pkg::res_t                 res_q, res_d;
  logic [smbe_pkg::NUM_CS-1:0]    mask_eff;
  logic                           phase_end;
  logic                           done;
  logic [W-1:0]                   rx;

  assign pop_o     = q_stat_i.not_empty && (!res_valid_q || res_o.ready);
  assign mask_eff  = entry_i.dev_mask & {cfg_i.gpio_cs_enable, 1'b1};
  assign phase_end = (tick_q >= cfg_i.half_period);

  always_comb begin
    shift_d   = shift_q;
    bit_cnt_d = bit_cnt_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    sel_d     = sel_q;
    active_d  = active_q;
    mosi_d    = mosi_q;
    done      = 1'b0;
    rx        = '0;
    if (active_q) begin
      if (!phase_q) begin
        if (phase_end) begin
          phase_d = 1'b1;
          tick_d  = smbe_pkg::HALF_W'(1);
        end else begin
          tick_d = tick_q + smbe_pkg::HALF_W'(1);
        end
      end else if (phase_end) begin
        shift_d   = {shift_q[W-2:0], entry_i.miso};
        bit_cnt_d = bit_cnt_q + smbe_pkg::BIT_CNT_W'(1);
        phase_d   = 1'b0;
        if (bit_cnt_d >= smbe_pkg::BIT_CNT_W'(W)) begin
          done      = 1'b1;
          rx        = shift_d;
          active_d  = 1'b0;
          bit_cnt_d = '0;
          tick_d    = '0;
        end else begin
          mosi_d = shift_d[W-1];
          tick_d = smbe_pkg::HALF_W'(1);
        end
      end else begin
        tick_d = tick_q + smbe_pkg::HALF_W'(1);
      end
    end else if (q_stat_i.not_empty) begin
      // only decode a queue slot that holds a request
      unique case (entry_i.cmd)
        smbe_pkg::CMD_TICK:     ;
        smbe_pkg::CMD_SELECT:   sel_d = sel_q & ~mask_eff;
        smbe_pkg::CMD_DESELECT: sel_d = sel_q | mask_eff;
        smbe_pkg::CMD_EXCHANGE: begin
          shift_d   = entry_i.tx_byte;
          bit_cnt_d = '0;
          phase_d   = 1'b0;
          tick_d    = smbe_pkg::HALF_W'(1);
          active_d  = 1'b1;
          mosi_d    = entry_i.tx_byte[W-1];
        end
      endcase
    end

    res_d.sclk        = active_d && phase_d;
    res_d.mosi        = mosi_d;
    res_d.cs_main_n   = sel_d[0];
    res_d.cs_gpio_a_n = cfg_i.gpio_cs_enable[0] ? sel_d[1] : 1'b1;
    res_d.cs_gpio_b_n = cfg_i.gpio_cs_enable[1] ? sel_d[2] : 1'b1;
    res_d.busy_res    = active_d;
    res_d.byte_done   = done;
    res_d.rx_byte     = rx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '1;
      bit_cnt_q   <= '0;
      phase_q     <= 1'b0;
      tick_q      <= '0;
      sel_q       <= '1;
      active_q    <= 1'b0;
      mosi_q      <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        shift_q     <= shift_d;
        bit_cnt_q   <= bit_cnt_d;
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        sel_q       <= sel_d;
        active_q    <= active_d;
        mosi_q      <= mosi_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

`ifndef SYNTHESIS
  a_sclk_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.payload.sclk || res_o.payload.busy_res))
    else $error("sclk high outside a transfer");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.byte_done |-> !res_o.payload.busy_res)
    else $error("byte_done while still busy");

  a_bit_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q < smbe_pkg::BIT_CNT_W'(W))
    else $error("bit counter out of range");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (tick_q == '0 && !phase_q))
    else $error("timing state left over after transfer");
`endif

endmodule

`default_nettype wire

### design/spi_master_mode0_byte_exchange.sv
// top level of the spi master (mode 0, msb first) byte exchange block
// path: an accepted request waits in the queue; its result is then offered
//   from the result register
// throughput: one request per cycle if the queue has room, one result per request;
//   one queued request is retired per cycle when the result register is free
// each request is one tick; a byte exchange spans 16 * max(half_period, 1) ticks
// reset: selects deselected, sclk low, mosi high, half_period 1, gpio selects off
`timescale 1ns / 1ps
`default_nettype none

module spi_master_mode0_byte_exchange (
  input  logic       clk_i,
  input  logic       rst_ni,
  smbe_req_if.sink   req_i,
  smbe_res_if.source res_o,
  smbe_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [smbe_pkg::HALF_W-1:0]    half_period_q;
  logic [smbe_pkg::GPIO_EN_W-1:0] gpio_cs_enable_q;
  smbe_pkg::cfg_t                 cfg;

  // front to queue to back
  logic              push;
  logic              pop;
  smbe_pkg::entry_t  entry_in;
  smbe_pkg::entry_t  entry_out;
  smbe_pkg::q_stat_t q_stat;

  // config writes are always taken; the user must send them only while the block is idle (not enforced here)
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q    <= smbe_pkg::HALF_W'(1);
      gpio_cs_enable_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        smbe_pkg::CFG_HALF_PERIOD: half_period_q <= cfg_i.payload.data;
        smbe_pkg::CFG_GPIO_CS_ENABLE:
          gpio_cs_enable_q <= cfg_i.payload.data[smbe_pkg::GPIO_EN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.half_period    = half_period_q;
  assign cfg.gpio_cs_enable = gpio_cs_enable_q;

  // front: take a request, decode command and device into a queue entry
  smbe_front u_front (
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (entry_in)
  );

  // two-entry queue decouples request acceptance from result backpressure
  smbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .pop_i   (pop),
    .entry_o (entry_out),
    .stat_o  (q_stat)
  );

  // back: advances the serial engine one tick per entry, registers the pins
  smbe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .entry_i  (entry_out),
    .pop_o    (pop),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire

### sim/tb_spi_master_mode0_byte_exchange.sv
// testbench for the spi master byte exchange block: tick-accurate pin prediction and checking
`timescale 1ns / 1ps

// predicts the pin levels of every tick and checks the results in order
class spi_pin_scoreboard;
  // copy of the block's registers
  logic [15:0] half_period;
  logic [1:0]  gpio_enable;
  // copy of the transfer engine and select state
  logic [7:0]  shift_bits;
  logic [3:0]  bits_done;
  logic        clock_high;
  logic [15:0] phase_ticks;
  logic [2:0]  select_n;
  logic        active;
  logic        mosi_level;

  smbe_pkg::res_t expected_pins[$];
  int unsigned    errors;
  int unsigned    checked;

  function new();
    half_period = 16'd1;
    gpio_enable = '0;
    shift_bits  = 8'hFF;
    bits_done   = '0;
    clock_high  = 1'b0;
    phase_ticks = '0;
    select_n    = 3'b111;
    active      = 1'b0;
    mosi_level  = 1'b1;
    errors      = 0;
    checked     = 0;
  endfunction

  function void write_reg(smbe_pkg::cfg_idx_e idx, logic [15:0] data);
    case (idx)
      smbe_pkg::CFG_HALF_PERIOD:    half_period = data;
      smbe_pkg::CFG_GPIO_CS_ENABLE: gpio_enable = data[1:0];
      default: ;
    endcase
  endfunction

  function bit dev_enabled(logic [1:0] dev);
    case (dev)
      smbe_pkg::DEV_MAIN:   return 1'b1;
      smbe_pkg::DEV_GPIO_A: return gpio_enable[0];
      smbe_pkg::DEV_GPIO_B: return gpio_enable[1];
      default:              return 1'b0;
    endcase
  endfunction

  // advance one tick and queue the pin levels it leaves behind
  function void take_request(smbe_pkg::req_t r);
    smbe_pkg::res_t pins;
    pins = '0;
    if (active) begin
      if (!clock_high) begin
        if (phase_ticks >= half_period) begin
          clock_high  = 1'b1;
          phase_ticks = 16'd1;
        end else begin
          phase_ticks = phase_ticks + 16'd1;
        end
      end else if (phase_ticks >= half_period) begin
        shift_bits = {shift_bits[6:0], r.miso};
        bits_done  = bits_done + 4'd1;
        clock_high = 1'b0;
        if (bits_done >= smbe_pkg::BITS_PER_WORD) begin
          pins.byte_done = 1'b1;
          pins.rx_byte   = shift_bits;
          active         = 1'b0;
          bits_done      = '0;
          phase_ticks    = '0;
        end else begin
          mosi_level  = shift_bits[7];
          phase_ticks = 16'd1;
        end
      end else begin
        phase_ticks = phase_ticks + 16'd1;
      end
    end else begin
      case (r.command)
        smbe_pkg::CMD_SELECT: if (dev_enabled(r.device)) select_n[r.device] = 1'b0;
        smbe_pkg::CMD_DESELECT: if (dev_enabled(r.device)) select_n[r.device] = 1'b1;
        smbe_pkg::CMD_EXCHANGE: begin
          shift_bits  = r.tx_byte;
          bits_done   = '0;
          clock_high  = 1'b0;
          phase_ticks = 16'd1;
          active      = 1'b1;
          mosi_level  = r.tx_byte[7];
        end
        default: ;
      endcase
    end
    pins.sclk        = active & clock_high;
    pins.mosi        = mosi_level;
    pins.cs_main_n   = select_n[0];
    pins.cs_gpio_a_n = gpio_enable[0] ? select_n[1] : 1'b1;
    pins.cs_gpio_b_n = gpio_enable[1] ? select_n[2] : 1'b1;
    pins.busy_res    = active;
    expected_pins.push_back(pins);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 100) $display("mismatch: %s", msg);
  endtask

  task check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
  endtask

  task check_pins(smbe_pkg::res_t got);
    smbe_pkg::res_t want;
    if (expected_pins.size() == 0) begin
      report($sformatf("result %0d arrived with nothing pending (%h)", checked, got));
      checked++;
      return;
    end
    want = expected_pins.pop_front();
    check_field("sclk", 8'(got.sclk), 8'(want.sclk));
    check_field("mosi", 8'(got.mosi), 8'(want.mosi));
    check_field("cs_main_n", 8'(got.cs_main_n), 8'(want.cs_main_n));
    check_field("cs_gpio_a_n", 8'(got.cs_gpio_a_n), 8'(want.cs_gpio_a_n));
    check_field("cs_gpio_b_n", 8'(got.cs_gpio_b_n), 8'(want.cs_gpio_b_n));
    check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
    check_field("byte_done", 8'(got.byte_done), 8'(want.byte_done));
    check_field("rx_byte", got.rx_byte, want.rx_byte);
    checked++;
  endtask
endclass

module tb_spi_master_mode0_byte_exchange;

  // device code that names no select line
  localparam logic [1:0]  DEV_NONE      = 2'd3;
  localparam int unsigned NO_XFER_CAP   = 32'hFFFF_FFFF;
  // worst case is far below this, even with heavy stalls
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // each result passes through the queue and the result register after its request
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned cycle_count = 0;

  smbe_req_if req_if ();
  smbe_res_if res_if ();
  smbe_cfg_if cfg_if ();

  spi_pin_scoreboard sb;

  // sender burst state
  int unsigned burst_left = 0;

  spi_master_mode0_byte_exchange u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check every accepted result, stall on a rotating random mask
  initial begin : result_sink
    logic [15:0] stall_mask;
    logic [3:0]  stall_pos;
    stall_mask = '0;
    stall_pos  = '0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) sb.check_pins(res_if.payload);
      if (stall_pos == 4'd0) begin
        // a fresh mask each time the position wraps: none, heavy or light stalling
        case ($urandom_range(0, 3))
          0:       stall_mask = '0;
          1:       stall_mask = 16'($urandom | $urandom);
          default: stall_mask = 16'($urandom & $urandom);
        endcase
      end
      res_if.ready <= rst_ni && !stall_mask[stall_pos];
      stall_pos = stall_pos + 4'd1;
    end
  end

  function automatic smbe_pkg::req_t mk_req(smbe_pkg::cmd_e cmd, logic [1:0] dev,
                                            logic [7:0] tx, logic miso);
    smbe_pkg::req_t r;
    r.command = cmd;
    r.device  = dev;
    r.tx_byte = tx;
    r.miso    = miso;
    return r;
  endfunction

  // one request = one tick; bursts of random length with random gaps
  task automatic send_req(smbe_pkg::req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.take_request(r);
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    while (sb.expected_pins.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(smbe_pkg::cfg_idx_e idx, logic [15:0] data);
    smbe_pkg::cfg_req_t w;
    w.index = idx;
    w.data  = data;
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  // registers change only with the block idle and every result collected
  task automatic configure(logic [15:0] half, logic [1:0] gpio_en);
    req_if.valid <= 1'b0;
    drain_results();
    write_reg(smbe_pkg::CFG_HALF_PERIOD, half);
    // upper data bits are junk the block must drop
    write_reg(smbe_pkg::CFG_GPIO_CS_ENABLE, {14'($urandom), gpio_en});
    cfg_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // random traffic: n_idle requests seen by an idle block, plus every tick of
  // the transfers they start; commands during a transfer must be ignored
  task automatic run_phase(int unsigned n_idle, int unsigned max_xfer);
    int unsigned    idle_items;
    int unsigned    xfers;
    int unsigned    pick;
    smbe_pkg::req_t r;
    idle_items = 0;
    xfers      = 0;
    while (idle_items < n_idle || sb.active) begin
      r.miso = 1'($urandom_range(0, 1));
      if (sb.active) begin
        r.command = 2'($urandom_range(0, 3));
        r.device  = 2'($urandom_range(0, 3));
        r.tx_byte = 8'($urandom_range(0, 255));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      r.command = smbe_pkg::CMD_EXCHANGE;
        else if (pick < 65) r.command = smbe_pkg::CMD_SELECT;
        else if (pick < 90) r.command = smbe_pkg::CMD_DESELECT;
        else                r.command = smbe_pkg::CMD_TICK;
        r.device = ($urandom_range(0, 9) == 0) ? DEV_NONE : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 7))
          0:       r.tx_byte = 8'h00;
          1:       r.tx_byte = 8'hFF;  // receive only
          default: r.tx_byte = 8'($urandom_range(0, 255));
        endcase
        if (r.command == smbe_pkg::CMD_EXCHANGE) begin
          if (xfers >= max_xfer) r.command = smbe_pkg::CMD_SELECT;
          else xfers++;
        end
        idle_items++;
      end
      send_req(r);
    end
  endtask

  initial begin : stimulus
    int k;
    sb = new();
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config (half period 1, gpio selects disabled)
    send_req(mk_req(smbe_pkg::CMD_SELECT, smbe_pkg::DEV_MAIN, 8'h00, 1'b0));
    // disabled gpio select
    send_req(mk_req(smbe_pkg::CMD_SELECT, smbe_pkg::DEV_GPIO_A, 8'h00, 1'b1));
    // unknown device
    send_req(mk_req(smbe_pkg::CMD_SELECT, DEV_NONE, 8'hFF, 1'b0));
    // disabled gpio deselect
    send_req(mk_req(smbe_pkg::CMD_DESELECT, smbe_pkg::DEV_GPIO_B, 8'hFF, 1'b1));
    send_req(mk_req(smbe_pkg::CMD_EXCHANGE, smbe_pkg::DEV_MAIN, 8'h80, 1'b0));
    // commands during the transfer, the byte_done tick included, do nothing
    k = 0;
    while (sb.active) begin
      send_req(mk_req(smbe_pkg::cmd_e'(k[1:0]), k[1:0], ~8'(k), k[1]));
      k++;
    end
    // mosi keeps the last bit sent from here on
    send_req(mk_req(smbe_pkg::CMD_DESELECT, smbe_pkg::DEV_MAIN, 8'hFF, 1'b1));
    send_req(mk_req(smbe_pkg::CMD_DESELECT, DEV_NONE, 8'h00, 1'b0));
    send_req(mk_req(smbe_pkg::CMD_TICK, smbe_pkg::DEV_GPIO_B, 8'hFF, 1'b1));

    // random phases across register settings
    run_phase(60, 4);
    configure(16'd1, 2'd3);
    run_phase(80, 5);
    configure(16'd0, 2'd1);     // zero half period behaves like one
    run_phase(60, 4);
    configure(16'd2, 2'd2);
    run_phase(60, 3);
    configure(16'd3, 2'd3);
    run_phase(60, 2);
    // largest half period: selects only, a byte would take a million ticks
    configure(16'hFFFF, 2'd3);
    run_phase(30, 0);
    // one slow byte
    configure(16'd8, 2'd0);
    send_req(mk_req(smbe_pkg::CMD_EXCHANGE, smbe_pkg::DEV_MAIN, 8'($urandom), 1'($urandom)));
    run_phase(10, 0);
    repeat (3) begin
      configure(16'($urandom_range(1, 5)), 2'($urandom_range(0, 3)));
      run_phase(40, 1);
    end

    req_if.valid <= 1'b0;
    drain_results();
    if (sb.expected_pins.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_pins.size()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
design/smbe_pkg.sv
design/smbe_if.sv
design/smbe_front.sv
design/smbe_queue.sv
design/smbe_back.sv
design/spi_master_mode0_byte_exchange.sv
sim/tb_spi_master_mode0_byte_exchange.sv
